[rtl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_TERM  = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  localparam int unsigned ACC_W   = 31;
  localparam int unsigned LEFT_W  = 3;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned CFG_W   = 21;

  localparam logic [CFG_W-1:0]   MAX_CP_RESET = 21'h0EFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [15:0]        HI_SURR_BASE = 16'hD800;
  localparam logic [15:0]        HI_SURR_ADJ  = 16'h0040;
  localparam logic [5:0]         LO_SURR_TAG  = 6'b110111;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // One result word
  typedef struct packed {
    logic [15:0]        word;
    result_kind_e       kind;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // Results produced by one decoded byte
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } dec_out_t;

endpackage

[rtl/u8u16_decoder.sv]
// ----------------------------------------------------------------------------
// u8u16_decoder
// Per-byte UTF-8 decode with sequence state, emitting up to two results.
// ----------------------------------------------------------------------------
module u8u16_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      take_i,
  input  logic [7:0]                byte_i,
  input  logic [u8u16_pkg::CFG_W-1:0] max_cp_i,
  output u8u16_pkg::dec_out_t       res_o
);
  import u8u16_pkg::*;

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;

  logic [COUNT_W-1:0] bump1, bump2;
  logic [ACC_W-1:0]   acc_new, cp;
  logic               emit, err;
  logic [15:0]        hi_word;

  // saturating word counts for one or two new words
  assign bump1 = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
  assign bump2 = (bump1 == COUNT_MAX) ? bump1 : bump1 + 1'b1;

  assign acc_new = {acc_q[ACC_W-7:0], byte_i[5:0]};
  assign hi_word = HI_SURR_BASE + cp[25:10] - HI_SURR_ADJ;

  // decode
  always_comb begin
    acc_d  = acc_q;
    left_d = left_q;
    cnt_d  = cnt_q;
    emit   = 1'b0;
    err    = 1'b0;
    cp     = '0;
    res_o  = '{num: 2'd0,
               r0: '{word: 16'h0, kind: KIND_DATA, count: '0, last: 1'b1},
               r1: '{word: 16'h0, kind: KIND_DATA, count: '0, last: 1'b1}};

    if (left_q != '0) begin
      if (byte_i[7:6] != 2'b10) begin
        err = 1'b1;
      end else if (left_q == LEFT_W'(1)) begin
        emit = 1'b1;
        cp   = acc_new;
      end else begin
        acc_d  = acc_new;
        left_d = left_q - 1'b1;
      end
    end else if (byte_i == 8'h00) begin
      // string terminator carries the running count
      res_o.num      = 2'd1;
      res_o.r0.kind  = KIND_TERM;
      res_o.r0.count = cnt_q;
      acc_d  = '0;
      left_d = '0;
      cnt_d  = '0;
    end else if (!byte_i[7]) begin
      emit = 1'b1;
      cp   = ACC_W'(byte_i);
    end else if (byte_i < 8'hC0 || byte_i > 8'hFD) begin
      err = 1'b1;
    end else begin
      // lead byte opens a sequence
      priority if (byte_i < 8'hE0) begin
        acc_d  = ACC_W'(byte_i[4:0]);
        left_d = LEFT_W'(1);
      end else if (byte_i < 8'hF0) begin
        acc_d  = ACC_W'(byte_i[3:0]);
        left_d = LEFT_W'(2);
      end else if (byte_i < 8'hF8) begin
        acc_d  = ACC_W'(byte_i[2:0]);
        left_d = LEFT_W'(3);
      end else if (byte_i < 8'hFC) begin
        acc_d  = ACC_W'(byte_i[1:0]);
        left_d = LEFT_W'(4);
      end else begin
        acc_d  = ACC_W'(byte_i[0]);
        left_d = LEFT_W'(5);
      end
    end

    // finished code point: one word, a surrogate pair or an error
    if (emit) begin
      acc_d  = '0;
      left_d = '0;
      if (cp[ACC_W-1:16] == '0) begin
        res_o.num      = 2'd1;
        res_o.r0.word  = cp[15:0];
        res_o.r0.count = bump1;
        cnt_d          = bump1;
      end else if (cp <= ACC_W'(max_cp_i)) begin
        res_o.num      = 2'd2;
        res_o.r0.word  = hi_word;
        res_o.r0.count = bump1;
        res_o.r0.last  = 1'b0;
        res_o.r1.word  = {LO_SURR_TAG, cp[9:0]};
        res_o.r1.count = bump2;
        cnt_d          = bump2;
      end else begin
        err = 1'b1;
      end
    end

    if (err) begin
      res_o.num     = 2'd1;
      res_o.r0.word = 16'h0;
      res_o.r0.kind = KIND_ERROR;
      res_o.r0.count = '0;
      res_o.r0.last = 1'b1;
      acc_d  = '0;
      left_d = '0;
      cnt_d  = '0;
    end
  end

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
      cnt_q  <= '0;
    end else if (take_i) begin
      acc_q  <= acc_d;
      left_q <= left_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/u8u16_out_fifo.sv]
// ----------------------------------------------------------------------------
// u8u16_out_fifo
// Small result queue: up to two words in per cycle, one word out per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module u8u16_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  u8u16_pkg::dec_out_t  din_i,
  output logic                 room2_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output u8u16_pkg::result_t   head_o
);
  import u8u16_pkg::*;

  result_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0]   count_q;
  logic [FIFO_AW-1:0]   wr_ptr1;
  logic [1:0]           n_push;
  logic                 pop;

  assign n_push  = push_i ? din_i.num : 2'd0;
  assign pop     = valid_o && ready_i;
  assign wr_ptr1 = wr_ptr_q + 1'b1;

  assign valid_o = (count_q != '0);
  assign room2_o = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= din_i.r0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr1] <= din_i.r1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CW'(n_push) - FIFO_CW'(pop);
    end
  end

endmodule

[rtl/utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// UTF-8 byte stream in, UTF-16 words with terminator and error marks out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o, utf8_byte_i) takes one byte per
//   transfer. Output channel (out_valid_o / out_ready_i) delivers one result per
//   transfer: utf16_word_o, result_kind_o (data, terminator, error), word_count_o
//   and last_o, which marks the final result caused by a byte.
//   A byte is held in the input register, decoded and written into a
//   four-entry result queue, whose head is offered on the output port.
//   One byte is taken per cycle while the queue has room for two results;
//   a byte that completes a code point above 0xFFFF and not above the limit
//   gives a surrogate pair of two output words, so the output port sets the
//   rate at one word per cycle while out_ready_i is high.
//   A zero byte in lead position closes a string and reports its word count.
//   cfg_we_i / cfg_wdata_i write the largest code point sent as a pair;
//   write it only while the block is idle.
//   Reset empties the queue, clears the decode state and sets the limit to
//   0xEFFFF. When the receiver stalls the queue fills and in_ready_o drops
//   once fewer than two entries are free; nothing is lost.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [u8u16_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  utf8_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 utf16_word_o,
  output logic [1:0]                  result_kind_o,
  output logic [u8u16_pkg::COUNT_W-1:0] word_count_o,
  output logic                        last_o
);
  import u8u16_pkg::*;

  logic [CFG_W-1:0] max_cp_q;
  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             room2, take;
  dec_out_t         dec_res;
  result_t          head;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cp_q <= MAX_CP_RESET;
    end else if (cfg_we_i) begin
      max_cp_q <= cfg_wdata_i;
    end
  end

  // input register
  assign take       = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= utf8_byte_i;
    end
  end

  u8u16_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .byte_i   (byte_q),
    .max_cp_i (max_cp_q),
    .res_o    (dec_res)
  );

  u8u16_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (take),
    .din_i   (dec_res),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .head_o  (head)
  );

  assign utf16_word_o  = head.word;
  assign result_kind_o = head.kind;
  assign word_count_o  = head.count;
  assign last_o        = head.last;

endmodule
